// ----- rtl/iaet_pkg.sv -----
// Shared types and constants for the idle-age eviction table.
// Has no dependencies. The interfaces, the store and the top level use it.
package iaet_pkg;

  localparam int TAG_W   = 16;
  localparam int TIME_W  = 32;
  localparam int TOTAL_W = 6;
  localparam int KIND_W  = 2;
  localparam int REG_W   = 32;
  localparam int RIDX_W  = 1;

  localparam logic [KIND_W-1:0] KIND_INS_OK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INS_FULL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVICTED  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE     = 2'd3;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SWEEP  = 1'b1;

  localparam logic [RIDX_W-1:0] REG_IDLE_LIMIT   = 1'd0;
  localparam logic [RIDX_W-1:0] REG_REPORT_LIMIT = 1'd1;

  localparam logic [TIME_W-1:0]  IDLE_LIMIT_RST   = 32'd86400;
  localparam logic [TOTAL_W-1:0] REPORT_LIMIT_RST = 6'd32;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              auto_flag;
    logic              path_flag;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic   en;
    entry_t entry;
  } store_wr_t;

endpackage

// ----- rtl/iaet_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on iaet_pkg for field widths.
interface iaet_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [iaet_pkg::TAG_W-1:0]   entry_tag;
  logic                         entry_auto;
  logic                         entry_has_path;
  logic [iaet_pkg::TIME_W-1:0]  entry_time;
  logic [iaet_pkg::TIME_W-1:0]  now_time;

  modport source (output valid, req_type, entry_tag, entry_auto, entry_has_path,
                  entry_time, now_time, input ready);
  modport sink (input valid, req_type, entry_tag, entry_auto, entry_has_path,
                entry_time, now_time, output ready);
endinterface

interface iaet_res_if;
  logic                         valid;
  logic                         ready;
  logic [iaet_pkg::KIND_W-1:0]  result_kind;
  logic [iaet_pkg::TAG_W-1:0]   evicted_tag;
  logic                         listed;
  logic [iaet_pkg::TOTAL_W-1:0] evicted_total;
  logic                         last;

  modport source (output valid, result_kind, evicted_tag, listed, evicted_total, last,
                  input ready);
  modport sink (input valid, result_kind, evicted_tag, listed, evicted_total, last,
                output ready);
endinterface

// ----- rtl/idle_age_eviction_table.sv -----
// Idle-age eviction table, top level. Depends on iaet_pkg, iaet_if and iaet_store.
//
// An insert gives one result. A sweep walks the table once with
// a read pointer and a write pointer over a single-port-write entry memory: each entry
// passes through a memory read, then one subtract-and-compare of its idle time;
// evictions and the done result wait while the result channel stalls. Kept entries
// are copied down to the write pointer, which keeps order. No new request is taken
// until the sweep done result has been loaded.
module idle_age_eviction_table #(
  parameter int CAPACITY = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [iaet_pkg::RIDX_W-1:0]   cfg_index,
  input  logic [iaet_pkg::REG_W-1:0]    cfg_data,
  iaet_req_if.sink                      req,
  iaet_res_if.source                    res
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  logic [1:0]                     state;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  rd;
  logic [CW-1:0]                  wr;
  logic [iaet_pkg::TOTAL_W-1:0]   evicted;
  logic [iaet_pkg::TIME_W-1:0]    now;
  logic [iaet_pkg::TIME_W-1:0]    idle_limit;
  logic [iaet_pkg::TOTAL_W-1:0]   report_limit;

  logic                           o_valid;
  logic [iaet_pkg::KIND_W-1:0]    o_kind;
  logic [iaet_pkg::TAG_W-1:0]     o_tag;
  logic                           o_listed;
  logic [iaet_pkg::TOTAL_W-1:0]   o_total;
  logic                           o_last;

  iaet_pkg::store_wr_t            st_wr;
  logic [IW-1:0]                  st_wr_addr;
  iaet_pkg::entry_t               rd_data;

  logic                           out_free;
  logic                           req_xfer;
  logic                           has_room;
  logic [iaet_pkg::TIME_W:0]      diff;
  logic                           evict;
  logic                           listed_now;
  logic                           o_load;

  assign out_free = !o_valid || res.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign req_xfer = req.valid && req.ready;
  assign has_room = count < CW'(CAPACITY);

  assign diff = {1'b0, now} - {1'b0, rd_data.stamp};
  assign evict = rd_data.auto_flag && !diff[iaet_pkg::TIME_W] &&
                 (diff[iaet_pkg::TIME_W-1:0] > idle_limit);
  assign listed_now = rd_data.path_flag && (evicted < report_limit);

  assign o_load = ((state == ST_IDLE) && req_xfer &&
                   (req.req_type == iaet_pkg::REQ_INSERT)) ||
                  ((state == ST_READ) && (rd == count) && out_free) ||
                  ((state == ST_EVAL) && evict && out_free);

  always_comb begin
    st_wr.en    = 1'b0;
    st_wr.entry = rd_data;
    st_wr_addr  = wr[IW-1:0];
    if (state == ST_IDLE) begin
      st_wr.en              = req_xfer && (req.req_type == iaet_pkg::REQ_INSERT) && has_room;
      st_wr.entry.tag       = req.entry_tag;
      st_wr.entry.auto_flag = req.entry_auto;
      st_wr.entry.path_flag = req.entry_has_path;
      st_wr.entry.stamp     = req.entry_time;
      st_wr_addr            = count[IW-1:0];
    end else if (state == ST_EVAL) begin
      st_wr.en = !evict;
    end
  end

  iaet_store #(.CAPACITY(CAPACITY)) u_store (
    .clk     (clk),
    .wr      (st_wr),
    .wr_addr (st_wr_addr),
    .rd_addr (rd[IW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      o_valid      <= 1'b0;
      idle_limit   <= iaet_pkg::IDLE_LIMIT_RST;
      report_limit <= iaet_pkg::REPORT_LIMIT_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          iaet_pkg::REG_IDLE_LIMIT:   idle_limit <= cfg_data;
          iaet_pkg::REG_REPORT_LIMIT: report_limit <= cfg_data[iaet_pkg::TOTAL_W-1:0];
          default: ;
        endcase
      end
      if (res.ready && !o_load) begin
        o_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_xfer) begin
            if (req.req_type == iaet_pkg::REQ_SWEEP) begin
              rd      <= '0;
              wr      <= '0;
              evicted <= '0;
              now     <= req.now_time;
              state   <= ST_READ;
            end else begin
              o_valid  <= 1'b1;
              o_kind   <= has_room ? iaet_pkg::KIND_INS_OK : iaet_pkg::KIND_INS_FULL;
              o_tag    <= '0;
              o_listed <= 1'b0;
              o_total  <= '0;
              o_last   <= 1'b1;
              if (has_room) begin
                count <= count + 1'b1;
              end
            end
          end
        end
        ST_READ: begin
          if (rd == count) begin
            if (out_free) begin
              o_valid  <= 1'b1;
              o_kind   <= iaet_pkg::KIND_DONE;
              o_tag    <= '0;
              o_listed <= 1'b0;
              o_total  <= evicted;
              o_last   <= 1'b1;
              count    <= wr;
              state    <= ST_IDLE;
            end
          end else begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (evict) begin
            if (out_free) begin
              o_valid  <= 1'b1;
              o_kind   <= iaet_pkg::KIND_EVICTED;
              o_tag    <= rd_data.tag;
              o_listed <= listed_now;
              o_total  <= evicted + 1'b1;
              o_last   <= 1'b0;
              evicted  <= evicted + 1'b1;
              rd       <= rd + 1'b1;
              state    <= ST_READ;
            end
          end else begin
            wr    <= wr + 1'b1;
            rd    <= rd + 1'b1;
            state <= ST_READ;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res.valid         = o_valid;
  assign res.result_kind   = o_kind;
  assign res.evicted_tag   = o_tag;
  assign res.listed        = o_listed;
  assign res.evicted_total = o_total;
  assign res.last          = o_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_ptr_order: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (wr <= rd && rd <= count))
    else $error("sweep pointers out of order");

  a_evict_tally: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (evicted == iaet_pkg::TOTAL_W'(rd - wr)))
    else $error("eviction tally does not match pointer gap");

  a_sweep_start: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && req.req_type == iaet_pkg::REQ_SWEEP) |=>
      (state == ST_READ && rd == '0 && wr == '0))
    else $error("sweep did not start from the first entry");

endmodule

// ----- rtl/iaet_store.sv -----
// Entry memory: one write port and one read port with registered read data.
// Depends on iaet_pkg for the entry type.
module iaet_store #(
  parameter int CAPACITY = 32,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                clk,
  input  iaet_pkg::store_wr_t wr,
  input  logic [IW-1:0]       wr_addr,
  input  logic [IW-1:0]       rd_addr,
  output iaet_pkg::entry_t    rd_data
);

  iaet_pkg::entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.entry;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
